@@ src/ndiv_pkg.sv @@
// ----------------------------------------------------------------------------
// ndiv_pkg
// Shared types and constants of the non-restoring divider core.
// ----------------------------------------------------------------------------
package ndiv_pkg;

  localparam int unsigned DefaultWidth = 16;
  localparam int unsigned DataW        = 16;
  localparam int unsigned TdataW       = 2 * DataW;

  typedef struct packed {
    logic load;
    logic shift;
    logic add_en;
    logic sub;
  } ctrl_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_FIX  = 3'b100
  } state_e;

endpackage

@@ src/ndiv_cell.sv @@
// ----------------------------------------------------------------------------
// ndiv_cell
// One bit slice of the divider: a bit of the partial remainder, of the
// quotient and of the divisor, with a full adder on the carry chain.
// ----------------------------------------------------------------------------
module ndiv_cell
  import ndiv_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  ctrl_t ctrl_i,
  input  logic  load_q_i,
  input  logic  load_m_i,
  input  logic  a_prev_i,
  input  logic  q_prev_i,
  input  logic  carry_i,
  output logic  carry_o,
  output logic  a_o,
  output logic  q_o,
  output logic  res_o
);

  logic a_q, a_d;
  logic q_q, q_d;
  logic m_q, m_d;
  logic a_src, b_op, sum;

  assign a_src   = ctrl_i.shift ? a_prev_i : a_q;
  assign b_op    = m_q ^ ctrl_i.sub;
  assign sum     = a_src ^ b_op ^ carry_i;
  assign carry_o = (a_src & b_op) | (a_src & carry_i) | (b_op & carry_i);

  always_comb begin
    a_d = a_q;
    q_d = q_q;
    m_d = m_q;
    if (ctrl_i.load) begin
      a_d = 1'b0;
      q_d = load_q_i;
      m_d = load_m_i;
    end else begin
      if (ctrl_i.add_en) begin
        a_d = sum;
      end
      if (ctrl_i.shift) begin
        q_d = q_prev_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= 1'b0;
      q_q <= 1'b0;
      m_q <= 1'b0;
    end else begin
      a_q <= a_d;
      q_q <= q_d;
      m_q <= m_d;
    end
  end

  assign a_o   = a_q;
  assign q_o   = q_q;
  assign res_o = ctrl_i.add_en ? sum : a_q;

endmodule

@@ src/nonrestoring_divider_core.sv @@
// ----------------------------------------------------------------------------
// nonrestoring_divider_core
// Unsigned non-restoring divider built from a row of bit-slice cells.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_axis carries one request per transfer: tdata holds the
//   dividend in the low half and the divisor in the high half. Master stream
//   m_axis returns quotient (low half) and remainder (high half).
//   A request is taken when tvalid and tready are both high.
//   A taken request runs through the shift/add-subtract steps of the cell
//   row (state S_RUN), then a correction step (state S_FIX) that loads
//   the result into the output register. The row holds one division at a
//   time: a new request is taken only while idle or in the correction
//   step of the previous one. The carry chain across the row sets the
//   cycle time.
//   A finished result sits in the output register. While the receiver
//   stalls with that register full, the next division runs to its
//   correction step and waits there; tready stays low meanwhile.
//   A zero divisor returns an all-ones quotient and the dividend as
//   remainder. Reset empties the output register and idles the row.
// ----------------------------------------------------------------------------
module nonrestoring_divider_core
  import ndiv_pkg::*;
#(
  parameter int unsigned WIDTH = DefaultWidth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [TdataW-1:0] s_axis_tdata_i,  // dividend_in[15:0], divisor_in[31:16]
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [TdataW-1:0] m_axis_tdata_o   // quotient_out[15:0], remainder_out[31:16]
);

  localparam int unsigned CntW = $clog2(WIDTH);

  state_e            state_q, state_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              sign_q, sign_d;
  logic              out_valid_q, out_valid_d;
  logic [DataW-1:0]  quot_q, quot_d;
  logic [DataW-1:0]  rem_q, rem_d;

  ctrl_t             ctrl;
  logic              accept, slot_free, fix_go;
  logic [WIDTH-1:0]  a_bit, q_bit, res_bit;
  logic [WIDTH:0]    carry;
  logic              sign_src, new_sign;

  logic [WIDTH+DataW-1:0] divd_ext, divs_ext, quot_ext, rem_ext;

  assign divd_ext = {{WIDTH{1'b0}}, s_axis_tdata_i[DataW-1:0]};
  assign divs_ext = {{WIDTH{1'b0}}, s_axis_tdata_i[TdataW-1:DataW]};
  assign quot_ext = {{DataW{1'b0}}, q_bit};
  assign rem_ext  = {{DataW{1'b0}}, res_bit};

  assign slot_free       = !out_valid_q || m_axis_tready_i;
  assign fix_go          = (state_q == S_FIX) && slot_free;
  assign s_axis_tready_o = (state_q == S_IDLE) || fix_go;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    ctrl        = '0;
    ctrl.load   = accept;
    case (state_q)
      S_RUN: begin
        ctrl.shift  = 1'b1;
        ctrl.add_en = 1'b1;
        ctrl.sub    = !sign_q;
      end
      S_FIX: begin
        ctrl.add_en = fix_go && sign_q;
      end
      default: ;
    endcase
  end

  assign carry[0] = ctrl.sub;

  for (genvar i = 0; i < WIDTH; i++) begin : g_cell
    logic a_prev, q_prev;
    if (i == 0) begin : g_first
      assign a_prev = q_bit[WIDTH-1];
      assign q_prev = !new_sign;
    end else begin : g_rest
      assign a_prev = a_bit[i-1];
      assign q_prev = q_bit[i-1];
    end
    ndiv_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .load_q_i (divd_ext[i]),
      .load_m_i (divs_ext[i]),
      .a_prev_i (a_prev),
      .q_prev_i (q_prev),
      .carry_i  (carry[i]),
      .carry_o  (carry[i+1]),
      .a_o      (a_bit[i]),
      .q_o      (q_bit[i]),
      .res_o    (res_bit[i])
    );
  end

  assign sign_src = ctrl.shift ? a_bit[WIDTH-1] : sign_q;
  assign new_sign = sign_src ^ ctrl.sub ^ carry[WIDTH];

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    sign_d      = sign_q;
    out_valid_d = out_valid_q;
    quot_d      = quot_q;
    rem_d       = rem_q;

    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    if (ctrl.add_en) begin
      sign_d = new_sign;
    end

    case (state_q)
      S_RUN: begin
        if (count_q == CntW'(WIDTH - 1)) begin
          count_d = '0;
          state_d = S_FIX;
        end else begin
          count_d = CntW'(count_q + 1'b1);
        end
      end
      S_FIX: begin
        if (fix_go) begin
          out_valid_d = 1'b1;
          quot_d      = quot_ext[DataW-1:0];
          rem_d       = rem_ext[DataW-1:0];
          state_d     = S_IDLE;
        end
      end
      default: ;
    endcase

    if (accept) begin
      sign_d  = 1'b0;
      count_d = '0;
      state_d = S_RUN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      sign_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      sign_q      <= sign_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {rem_q, quot_q};

endmodule

@@ src/ndiv_checker.sv @@
// ----------------------------------------------------------------------------
// ndiv_checker
// Port-level assertions for the non-restoring divider core.
// ----------------------------------------------------------------------------
module ndiv_checker
  import ndiv_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tvalid_i,
  input logic              s_axis_tready_o,
  input logic              m_axis_tvalid_o,
  input logic              m_axis_tready_i,
  input logic [TdataW-1:0] m_axis_tdata_o
);

  logic s_acc;
  assign s_acc = s_axis_tvalid_i && s_axis_tready_o;

  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> m_axis_tvalid_o)
    else $error("result valid dropped while stalled");

  a_out_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> $stable(m_axis_tdata_o))
    else $error("result data changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready_o)
    else $error("request taken while a division is running");

  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |-> ##2 !$rose(m_axis_tvalid_o))
    else $error("result appeared right after request");

endmodule

bind nonrestoring_divider_core ndiv_checker u_ndiv_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
